// ----- design/cpf_pkg.sv -----
// Package for the complementary pitch filter.
// Holds datapath widths shared by the filter top level, its square root and CORDIC
// units, and the CORDIC arctangent table. No dependencies.
package cpf_pkg;

	localparam int ROOT_W     = 24;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int Y0_W       = 25;
	localparam int XY_W       = 28;
	localparam int ANGLE_W    = 20;
	localparam int ATAN_N     = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_FRAC  = 30;

	// atan(2^-i) in Q.30
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

endpackage

// ----- design/cpf_isqrt.sv -----
// Iterative integer square root for the complementary pitch filter.
// Produces one root bit per cycle.
// Depends on cpf_pkg.
module cpf_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpf_pkg::RAD_W-1:0]   radicand,
	output logic                        done,
	output logic [cpf_pkg::ROOT_W-1:0]  root
);
	import cpf_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W+1:0]  rem_t;
	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [REM_W+1:0]  rem_n;

	always_comb begin
		rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = (rem_t >= trial);
		rem_n = ge ? (rem_t - trial) : rem_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_n[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- design/cpf_cordic.sv -----
// Iterative CORDIC vectoring unit for the complementary pitch filter.
// One micro-rotation per cycle, angle returned in Q.16 radians.
// Depends on cpf_pkg for widths and the arctangent table.
module cpf_cordic #(
	parameter int STEPS = 16,
	parameter int FRAC  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic        [cpf_pkg::ROOT_W-1:0]  x0,
	input  logic signed [cpf_pkg::Y0_W-1:0]    y0,
	output logic                               done,
	output logic signed [cpf_pkg::ANGLE_W-1:0] angle
);
	import cpf_pkg::*;

	localparam int ZW   = FRAC + 3;
	localparam int TSH  = ATAN_FRAC - FRAC;
	localparam int SH_R = (FRAC > 16) ? (FRAC - 16) : 0;
	localparam int SH_L = (FRAC < 16) ? (16 - FRAC) : 0;
	localparam logic signed [31:0] RND = (32'sd1 <<< SH_R) >>> 1;

	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [ZW-1:0]     z_q;
	logic [ATAN_IDX_W-1:0]    i_q;
	logic                     busy_q;
	logic                     done_q;

	logic signed [XY_W-1:0]   xs, ys;
	logic signed [ZW-1:0]     a;
	logic signed [31:0]       zw;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		a  = ZW'(ATAN_TAB[i_q] >> TSH);
		zw = 32'(z_q);
		angle = ANGLE_W'(((zw + RND) >>> SH_R) <<< SH_L);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == ATAN_IDX_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XY_W'({1'b0, x0});
			y_q <= XY_W'(y0);
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end
		end
	end

	assign done = done_q;

endmodule

// ----- design/complementary_pitch_filter.sv -----
// Complementary-filter pitch estimator, top level.
// A valid sample passes through two squares and two gyro scalings on one shared multiplier,
// a square root, the CORDIC rotations and three more multiplies; an invalid sample goes
// straight to the result stage. A new request is taken only when the sequencer is idle;
// input stalls until then, and the result stage waits while the output stalls.
// Reset: async active low; estimate and rates clear to zero, registers to defaults.
module complementary_pitch_filter #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic               read_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [19:0] pitch_angle,
	output logic signed [21:0] pitch_rate,
	output logic signed [21:0] yaw_rate,
	output logic               sample_valid
);
	import cpf_pkg::*;

	localparam logic [1:0] REG_PRESENT = 2'd0;
	localparam logic [1:0] REG_BLEND   = 2'd1;
	localparam logic [1:0] REG_STEP    = 2'd2;
	localparam logic [1:0] REG_GSCALE  = 2'd3;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_AY   = 4'd1;
	localparam logic [3:0] S_AZ   = 4'd2;
	localparam logic [3:0] S_GY   = 4'd3;
	localparam logic [3:0] S_GZ   = 4'd4;
	localparam logic [3:0] S_SQ   = 4'd5;
	localparam logic [3:0] S_SQW  = 4'd6;
	localparam logic [3:0] S_CRW  = 4'd7;
	localparam logic [3:0] S_PR   = 4'd8;
	localparam logic [3:0] S_PD   = 4'd9;
	localparam logic [3:0] S_M1   = 4'd10;
	localparam logic [3:0] S_M2   = 4'd11;
	localparam logic [3:0] S_MX   = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	localparam int MW = 25;
	localparam int PW = 2 * MW;
	localparam int XW = 42;

	// configuration
	logic        present_q;
	logic [15:0] blend_q;
	logic [23:0] step_q;
	logic [15:0] gscale_q;

	// sequencer and datapath
	logic [3:0]             state_q;
	logic                   ok_q;
	logic signed [15:0]     ax_q, ay_q, az_q, gy_q, gz_q;
	logic                   zero_q;
	logic [31:0]            sum_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [ANGLE_W-1:0] acc_q;
	logic signed [23:0]     pred_q;
	logic signed [XW-1:0]   mix_q;
	logic signed [19:0]     pitch_q;
	logic signed [21:0]     prate_q, yrate_q;

	// result register
	logic                   out_valid_q;
	logic signed [19:0]     out_angle_q;
	logic signed [21:0]     out_prate_q, out_yrate_q;
	logic                   out_ok_q;

	logic signed [MW-1:0]   mul_a, mul_b;
	logic                   in_take;
	logic                   out_load;
	logic                   sq_start, sq_done;
	logic [ROOT_W-1:0]      sq_root;
	logic                   cr_start, cr_done;
	logic signed [ANGLE_W-1:0] cr_angle;
	logic signed [Y0_W-1:0] nax;
	logic signed [XW-1:0]   mix_rnd;
	logic signed [19:0]     new_pitch;
	logic signed [PW-1:0]   pd_t;

	function automatic logic signed [21:0] rate_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + PW'(128)) >>> 8;
		if (t > PW'(2097151))
			return 22'sh1FFFFF;
		else if (t < -PW'(2097152))
			return 22'sh200000;
		return t[21:0];
	endfunction

	assign pready   = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign sq_start = (state_q == S_SQ);
	assign cr_start = (state_q == S_SQW) && sq_done;
	assign nax      = -Y0_W'(ax_q);

	always_comb begin
		mix_rnd = (mix_q + XW'(32768)) >>> 16;
		if (mix_rnd > XW'(524287))
			new_pitch = 20'sh7FFFF;
		else if (mix_rnd < -XW'(524288))
			new_pitch = 20'sh80000;
		else
			new_pitch = mix_rnd[19:0];
		pd_t = (prod_q + (PW'(1) <<< 23)) >>> 24;
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_AY: begin
				mul_a = MW'(ay_q);
				mul_b = MW'(ay_q);
			end
			S_AZ: begin
				mul_a = MW'(az_q);
				mul_b = MW'(az_q);
			end
			S_GY: begin
				mul_a = MW'(gy_q);
				mul_b = MW'({1'b0, gscale_q});
			end
			S_GZ: begin
				mul_a = MW'(gz_q);
				mul_b = MW'({1'b0, gscale_q});
			end
			S_PR: begin
				mul_a = MW'(prate_q);
				mul_b = MW'({1'b0, step_q});
			end
			S_M1: begin
				mul_a = MW'(pred_q);
				mul_b = MW'({1'b0, blend_q});
			end
			S_M2: begin
				mul_a = MW'(acc_q);
				mul_b = MW'(18'sd65536 - 18'($unsigned({1'b0, blend_q})));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			blend_q   <= 16'd64225;
			step_q    <= 24'd16777;
			gscale_q  <= 16'd5124;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_PRESENT: present_q <= pwdata[0];
				REG_BLEND:   blend_q   <= pwdata[15:0];
				REG_STEP:    step_q    <= pwdata[23:0];
				REG_GSCALE:  gscale_q  <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PRESENT: prdata = {31'd0, present_q};
			REG_BLEND:   prdata = {16'd0, blend_q};
			REG_STEP:    prdata = {8'd0, step_q};
			REG_GSCALE:  prdata = {16'd0, gscale_q};
			default:     prdata = '0;
		endcase
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ok_q        <= 1'b0;
			pitch_q     <= '0;
			prate_q     <= '0;
			yrate_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						ok_q    <= present_q && read_ok;
						state_q <= (present_q && read_ok) ? S_AY : S_FIN;
					end
				end
				S_AY:  state_q <= S_AZ;
				S_AZ:  state_q <= S_GY;
				S_GY:  state_q <= S_GZ;
				S_GZ: begin
					prate_q <= rate_sat(prod_q);
					state_q <= S_SQ;
				end
				S_SQ: begin
					yrate_q <= rate_sat(prod_q);
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (sq_done)
						state_q <= S_CRW;
				end
				S_CRW: begin
					if (cr_done)
						state_q <= S_PR;
				end
				S_PR:  state_q <= S_PD;
				S_PD:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_MX;
				S_MX:  state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						if (ok_q)
							pitch_q <= new_pitch;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gy_q <= gyro_y;
			gz_q <= gyro_z;
		end
		if (state_q == S_AY)
			zero_q <= (ax_q == '0) && (ay_q == '0) && (az_q == '0);
		if (state_q == S_AZ)
			sum_q <= prod_q[31:0];
		if (state_q == S_GY)
			sum_q <= sum_q + prod_q[31:0];
		if ((state_q == S_CRW) && cr_done)
			acc_q <= zero_q ? '0 : cr_angle;
		if (state_q == S_PD)
			pred_q <= 24'(pitch_q) + pd_t[23:0];
		if (state_q == S_M2)
			mix_q <= prod_q[XW-1:0];
		if (state_q == S_MX)
			mix_q <= mix_q + prod_q[XW-1:0];
		if (out_load) begin
			out_angle_q <= ok_q ? new_pitch : pitch_q;
			out_prate_q <= prate_q;
			out_yrate_q <= yrate_q;
			out_ok_q    <= ok_q;
		end
	end

	cpf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({sum_q, 16'd0}),
		.done     (sq_done),
		.root     (sq_root)
	);

	cpf_cordic #(
		.STEPS (CORDIC_STEPS),
		.FRAC  (FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cr_start),
		.x0     (sq_root),
		.y0     (nax <<< 8),
		.done   (cr_done),
		.angle  (cr_angle)
	);

	assign out_valid    = out_valid_q;
	assign pitch_angle  = out_angle_q;
	assign pitch_rate   = out_prate_q;
	assign yaw_rate     = out_yrate_q;
	assign sample_valid = out_ok_q;

endmodule
